// ===== rtl/core/length_checksum_frame_receiver_defines.svh =====
// Assertion macros for the length/checksum frame receiver.
`ifndef LENGTH_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LCFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lcfr_pkg.sv =====
// Shared types and constants for the length/checksum frame receiver.
`default_nettype none

package lcfr_pkg;

   // Status codes of a result
   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_OK       = 3'd1;
   localparam logic [2:0] ST_BAD_ID   = 3'd2;
   localparam logic [2:0] ST_BAD_SIZE = 3'd3;
   localparam logic [2:0] ST_BAD_SUM  = 3'd4;
   localparam logic [2:0] ST_DROPPED  = 3'd5;

   // Command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ARM  = 1'b1;

   // Configuration register map
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_ID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_SIZE = 2'd1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        data_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_id;
      logic [15:0] expected_size;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/length_checksum_frame_receiver.sv =====
// Top level of the length/checksum frame receiver.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_data  (cmd, rx_byte)
//   rsp      out        rsp_valid/rsp_stall rsp_data  (data_valid, byte, index, status)
//   csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// One transaction per cycle unless a held result stalls the flow; a transaction
// goes through the input register, then the parser logic, then the result register.
// Synchronous active-high reset clears both register valids and parser state.
// A held result blocks the parser; the input register still takes one more
// transaction, then req_stall rises until the result is taken.
`default_nettype none

module length_checksum_frame_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire lcfr_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output lcfr_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lcfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lcfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcfr_pkg::*;

   `include "length_checksum_frame_receiver_defines.svh"

   logic    in_vld_ff;
   req_type in_data_ff;
   logic    out_vld_ff;
   rsp_type out_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   lcfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcfr_deframe u_deframe (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Move from input register to result register when the latter is free
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || !rsp_stall) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   `LCFR_ASSERT_SAME(a_payload_busy, clock, reset, rsp_valid && rsp_data.data_valid, rsp_data.status == ST_BUSY, "payload byte with final status")
   `LCFR_ASSERT_SAME(a_idle_zero, clock, reset, rsp_valid && !rsp_data.data_valid, rsp_data.payload_byte == 8'd0 && rsp_data.payload_index == 16'd0, "non-payload result carries data")
   `LCFR_ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && out_vld_ff && rsp_stall, in_vld_ff && $stable(in_data_ff), "input register lost a blocked transaction")

endmodule

`default_nettype wire

// ===== rtl/core/lcfr_csr.sv =====
// Configuration registers: expected frame ID and expected payload size.
`default_nettype none

module lcfr_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lcfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lcfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lcfr_pkg::cfg_type                    cfg
);
   import lcfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_EXPECTED_ID:   cfg_in.expected_id   = csr_wdata[7:0];
            CSR_EXPECTED_SIZE: cfg_in.expected_size = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcfr_deframe.sv =====
// Frame parser: header checks, payload pass-through and checksum compare.
`default_nettype none

module lcfr_deframe (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire lcfr_pkg::req_type  item,
   input  wire lcfr_pkg::cfg_type  cfg,
   output lcfr_pkg::rsp_type       result
);
   import lcfr_pkg::*;

   typedef enum logic [1:0] {
      PH_ID     = 2'd0,
      PH_SIZE_H = 2'd1,
      PH_SIZE_L = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   logic        armed_ff, armed_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff,   sum_in;

   // Result and next state for the transaction in the input register
   always_comb begin
      result          = '0;
      result.status   = ST_BUSY;
      armed_in        = armed_ff;
      phase_in        = phase_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      if (item.cmd == CMD_ARM) begin
         armed_in = 1'b1;
         phase_in = PH_ID;
         count_in = '0;
         sum_in   = '0;
      end else if (!armed_ff) begin
         result.status = ST_DROPPED;
      end else begin
         case (phase_ff)
            PH_SIZE_H: begin
               if (item.rx_byte == cfg.expected_size[15:8]) begin
                  phase_in = PH_SIZE_L;
               end else begin
                  result.status = ST_BAD_SIZE;
                  armed_in      = 1'b0;
                  phase_in      = PH_ID;
               end
            end
            PH_SIZE_L: begin
               if (item.rx_byte == cfg.expected_size[7:0]) begin
                  phase_in = PH_BODY;
                  count_in = '0;
                  sum_in   = '0;
               end else begin
                  result.status = ST_BAD_SIZE;
                  armed_in      = 1'b0;
                  phase_in      = PH_ID;
               end
            end
            PH_BODY: begin
               if (count_ff < cfg.expected_size) begin
                  result.data_valid    = 1'b1;
                  result.payload_byte  = item.rx_byte;
                  result.payload_index = count_ff;
                  sum_in               = sum_ff + item.rx_byte;
                  count_in             = count_ff + 16'd1;
               end else begin
                  // trailing checksum byte
                  result.status = (item.rx_byte == sum_ff) ? ST_OK : ST_BAD_SUM;
                  armed_in      = 1'b0;
                  phase_in      = PH_ID;
               end
            end
            default: begin
               // expecting the ID byte
               if (item.rx_byte == cfg.expected_id) begin
                  phase_in = PH_SIZE_H;
               end else begin
                  result.status = ST_BAD_ID;
                  armed_in      = 1'b0;
                  phase_in      = PH_ID;
               end
            end
         endcase
      end
   end

   // Parser state moves only when the transaction goes to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         phase_ff <= PH_ID;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (fire) begin
         armed_ff <= armed_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

`default_nettype wire
